/* rtl/core/tme_pkg.sv */
// shared types and constants of the trimmed mean engine
// no dependencies; used by tme_cell and trimmed_mean_engine_top
package tme_pkg;

    // default depth of the sorting chain
    localparam int MAX_VALUES_DEFAULT = 64;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int TRIM_W   = 15;
    localparam int FRAC_W   = 16;
    localparam int KEPT_W   = 7;

    // one input beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_t;

    // one result beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [KEPT_W-1:0]          kept_count;
        logic                       overflow;
    } out_t;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

/* rtl/core/tme_cell.sv */
// one cell of the insertion sorting chain: holds one value and its valid bit
// depends on tme_pkg
module tme_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tme_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [tme_pkg::SAMPLE_W-1:0]  key,
    input  logic                                 prev_gt,
    input  logic                                 prev_vld,
    input  logic signed [tme_pkg::SAMPLE_W-1:0]  prev_val,
    input  logic                                 next_vld,
    input  logic signed [tme_pkg::SAMPLE_W-1:0]  next_val,
    output logic                                 vld,
    output logic signed [tme_pkg::SAMPLE_W-1:0]  val,
    output logic                                 gt
);

    logic                                vld_reg;
    logic                                vld_next;
    logic signed [tme_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [tme_pkg::SAMPLE_W-1:0] val_next;

    // empty cells count as greater than any key
    assign gt = !vld_reg || (val_reg > key);

    // insert moves the tail right by one; drain moves everything left
    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (ctrl.insert)
        begin
            if (gt)
            begin
                val_next = prev_gt ? prev_val : key;
                vld_next = vld_reg | prev_vld;
            end
        end
        else if (ctrl.shift)
        begin
            val_next = next_val;
            vld_next = next_vld;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign vld = vld_reg;
    assign val = val_reg;

endmodule

/* rtl/core/tme_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module tme_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg;
    logic             run_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] quot_reg;
    logic [NUM_W-1:0] quot_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one trial subtraction
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            num_next = num;
            den_next = den;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], ge};
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/core/trimmed_mean_engine_top.sv */
// top level of the trimmed mean engine: sorting chain, drain and sum, divider
// depends on tme_pkg, tme_cell, tme_divider
//
// Usage
//   Input: a beat (item.sample, item.last) is taken on a clock edge with start
//   high and busy low. Values of one row are taken one per cycle; each enters
//   a chain of MAX_VALUES compare-and-shift cells and lands in sorted order.
//   Values beyond MAX_VALUES are dropped and reported as overflow.
//   The beat with last set ends the row; busy then stays high while the
//   engine works out the trim bounds, drains the chain through the
//   accumulator, loads the divider, runs the restoring divider at one
//   quotient bit per cycle and takes the quotient.
//   Result: done is high for exactly one cycle with result valid; the
//   receiver cannot stall it. The next row may start in that same cycle.
//   Configuration: cfg_data is written when cfg_valid is high (cfg_ready is
//   always high); write it only while the engine is idle.
//   Reset: asynchronous, active low; empties the chain, zeroes the trim.
module trimmed_mean_engine_top #(
    parameter int MAX_VALUES = tme_pkg::MAX_VALUES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tme_pkg::in_t                   item,
    output logic                           done,
    output tme_pkg::out_t                  result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tme_pkg::TRIM_W-1:0]     cfg_data
);

    localparam int SW     = tme_pkg::SAMPLE_W;
    localparam int TW     = tme_pkg::TRIM_W;
    localparam int FW     = tme_pkg::FRAC_W;
    localparam int KW     = tme_pkg::KEPT_W;
    localparam int CW     = $clog2(MAX_VALUES + 1);
    localparam int PW     = CW + TW;
    localparam int SUM_W  = SW + CW;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = CW + 1;

    // control states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_DIV   = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [TW-1:0]         trim_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  drop_reg;
    logic                  drop_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         idx_next;
    logic [CW-1:0]         lo_reg;
    logic [CW-1:0]         lo_next;
    logic [CW-1:0]         hi_reg;
    logic [CW-1:0]         hi_next;
    logic [CW-1:0]         kept_reg;
    logic [CW-1:0]         kept_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                  done_reg;
    logic                  done_next;
    tme_pkg::out_t         result_reg;
    tme_pkg::out_t         result_next;

    logic                  accept;
    logic                  full;
    logic [PW-1:0]         trim_prod;
    logic [CW-1:0]         trim_cut;
    logic [SUM_W-1:0]      mag;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quot;
    logic [SW-1:0]         q_low;
    tme_pkg::cell_ctrl_t   cell_ctrl;

    logic                  cell_vld [MAX_VALUES];
    logic signed [SW-1:0]  cell_val [MAX_VALUES];
    logic                  cell_gt  [MAX_VALUES];

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(MAX_VALUES));
    assign cfg_ready = 1'b1;

    // chain command
    assign cell_ctrl.insert = accept && !full;
    assign cell_ctrl.shift  = (state_reg == ST_DRAIN);

    // sorting chain
    for (genvar i = 0; i < MAX_VALUES; i++)
    begin : g_cell
        logic                 p_gt;
        logic                 p_vld;
        logic signed [SW-1:0] p_val;
        logic                 n_vld;
        logic signed [SW-1:0] n_val;

        if (i == 0)
        begin : g_head
            assign p_gt  = 1'b0;
            assign p_vld = 1'b1;
            assign p_val = '0;
        end
        else
        begin : g_body
            assign p_gt  = cell_gt[i-1];
            assign p_vld = cell_vld[i-1];
            assign p_val = cell_val[i-1];
        end

        if (i == MAX_VALUES - 1)
        begin : g_tail
            assign n_vld = 1'b0;
            assign n_val = '0;
        end
        else
        begin : g_mid
            assign n_vld = cell_vld[i+1];
            assign n_val = cell_val[i+1];
        end

        tme_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .key      (item.sample),
            .prev_gt  (p_gt),
            .prev_vld (p_vld),
            .prev_val (p_val),
            .next_vld (n_vld),
            .next_val (n_val),
            .vld      (cell_vld[i]),
            .val      (cell_val[i]),
            .gt       (cell_gt[i])
        );
    end

    // number trimmed from each end: floor(count * trim)
    assign trim_prod = PW'(count_reg) * PW'(trim_reg);
    assign trim_cut  = CW'(trim_prod[PW-1:FW]);

    // divider operands: round half away from zero on the magnitude
    assign mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_num   = {mag, 1'b0} + NUM_W'(kept_reg);
    assign div_den   = {kept_reg, 1'b0};
    assign div_start = (state_reg == ST_LOAD);
    assign q_low     = div_quot[SW-1:0];

    tme_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        kept_next   = kept_reg;
        sum_next    = sum_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (item.last)
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                lo_next    = trim_cut;
                hi_next    = count_reg - 1'b1 - trim_cut;
                kept_next  = count_reg - {trim_cut[CW-2:0], 1'b0};
                sum_next   = '0;
                idx_next   = '0;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // head of the chain is sorted entry idx
                if (idx_reg >= lo_reg && idx_reg <= hi_reg)
                begin
                    sum_next = sum_reg + SUM_W'(cell_val[0]);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(count_reg - 1'b1))
                begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_next.mean       = sum_reg[SUM_W-1] ? -q_low : q_low;
                    result_next.kept_count = KW'(kept_reg);
                    result_next.overflow   = drop_reg;
                    drop_next              = 1'b0;
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
            trim_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                trim_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        kept_reg   <= kept_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a result only follows a divide
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DIV))
        else $error("result beat without a finished divide");

    // a value without the last mark never makes the engine busy
    a_plain_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("engine went busy on a beat without last");

    // the head cell of the chain is empty and the row count cleared when the result leaves
    a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!cell_vld[0] && count_reg == '0))
        else $error("chain not drained at result");

    // the divider finishes only while the sequencer waits for it
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule
